// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    localparam logic       CMD_PUT              = 1'b0;
    localparam logic       CMD_READ             = 1'b1;

    localparam logic [7:0] CODE_BACKSPACE       = 8'd8;
    localparam logic [7:0] CODE_LINE_FEED       = 8'd10;
    localparam logic [7:0] CODE_CARRIAGE_RETURN = 8'd13;
    localparam logic [7:0] SPACE_CHAR           = 8'd32;
    localparam logic [7:0] REVERSE_BIT          = 8'h80;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_WR_OLD,
        ST_SCROLL,
        ST_FILL,
        ST_RD_NEW,
        ST_WR_NEW,
        ST_DONE
    } tcw_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_FETCH,
        OP_WR_OLD,
        OP_SCROLL,
        OP_FILL,
        OP_RD_CUR,
        OP_WR_NEW
    } tcw_op_t;

    typedef struct packed {
        logic    capture;
        tcw_op_t op;
        logic    cnt_clr;
        logic    out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic cnt_at_end;
        logic cnt_at_shift;
        logic is_read;
        logic need_scroll;
        logic out_busy;
    } tcw_status_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t        cmd
);
    import tcw_pkg::*;

    tcw_state_t state_reg;
    tcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = status.is_read ? ST_DONE : ST_WR_OLD;
            end
            ST_WR_OLD:
            begin
                state_next = status.need_scroll ? ST_SCROLL : ST_RD_NEW;
            end
            ST_SCROLL:
            begin
                if (status.cnt_at_shift)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (status.cnt_at_end)
                begin
                    state_next = ST_RD_NEW;
                end
            end
            ST_RD_NEW:
            begin
                state_next = ST_WR_NEW;
            end
            ST_WR_NEW:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = OP_NONE;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_FETCH:
            begin
                cmd.op = OP_FETCH;
            end
            ST_WR_OLD:
            begin
                cmd.op      = OP_WR_OLD;
                cmd.cnt_clr = 1'b1;
            end
            ST_SCROLL:
            begin
                cmd.op = OP_SCROLL;
            end
            ST_FILL:
            begin
                cmd.op = OP_FILL;
            end
            ST_RD_NEW:
            begin
                cmd.op = OP_RD_CUR;
            end
            ST_WR_NEW:
            begin
                cmd.op = OP_WR_NEW;
            end
            ST_DONE:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_dp.sv =====
`default_nettype none

module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcw_pkg::tcw_cmd_t   cmd,
    output tcw_pkg::tcw_status_t     status,
    input  wire logic                command,
    input  wire logic [7:0]          symbol,
    input  wire logic [4:0]          read_row,
    input  wire logic [6:0]          read_col,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               cell_value,
    output logic [6:0]               cursor_col,
    output logic [4:0]               cursor_row
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SHIFT_LAST = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

    logic [7:0] mem [CELLS];

    logic              cmd_reg;
    logic [7:0]        sym_reg;
    logic [4:0]        rrow_reg;
    logic [6:0]        rcol_reg;
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        cell_value_reg;
    logic [7:0]        cell_value_next;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_col_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [ROW_W-1:0]  out_row_next;

    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    logic [31:0]       cur_addr_full;
    logic [31:0]       read_addr_full;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              in_range;
    logic              is_ctrl;
    logic              is_lf;
    logic [31:0]       col_wide;
    logic [31:0]       row_wide;

    assign cur_addr_full  = 32'(row_reg) * COLUMNS + 32'(col_reg);
    assign read_addr_full = 32'(rrow_reg) * COLUMNS + 32'(rcol_reg);
    assign cur_addr       = cur_addr_full[ADDR_W-1:0];
    assign read_addr      = read_addr_full[ADDR_W-1:0];
    assign in_range       = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);
    assign is_ctrl        = sym_reg inside {CODE_BACKSPACE, CODE_LINE_FEED,
                                            CODE_CARRIAGE_RETURN};
    assign is_lf          = (sym_reg == CODE_LINE_FEED);

    assign status.cnt_at_end   = (cnt_reg == ADDR_LAST);
    assign status.cnt_at_shift = (cnt_reg == SHIFT_LAST);
    assign status.is_read      = (cmd_reg == CMD_READ);
    assign status.need_scroll  = (row_reg == ROW_LAST) &&
                                 (is_lf || (!is_ctrl && col_reg == COL_LAST));
    assign status.out_busy     = out_valid_reg && out_stall;

    // memory port control
    always_comb
    begin
        rd_en = 1'b0;
        raddr = cur_addr;
        wr_en = 1'b0;
        waddr = cur_addr;
        wdata = rdata_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                wr_en = 1'b1;
                waddr = cnt_reg;
                wdata = (cnt_reg == '0) ? REVERSE_BIT : 8'd0;
            end
            OP_FETCH:
            begin
                rd_en = 1'b1;
                raddr = (cmd_reg == CMD_READ) ? read_addr : cur_addr;
            end
            OP_WR_OLD:
            begin
                wr_en = 1'b1;
                wdata = is_ctrl ? (rdata_reg ^ REVERSE_BIT) : sym_reg;
            end
            OP_SCROLL:
            begin
                rd_en = !status.cnt_at_shift;
                raddr = cnt_reg + ROW_STEP;
                wr_en = (cnt_reg != '0);
                waddr = cnt_reg - 1'b1;
            end
            OP_FILL:
            begin
                wr_en = 1'b1;
                waddr = cnt_reg;
                wdata = SPACE_CHAR;
            end
            OP_RD_CUR:
            begin
                rd_en = 1'b1;
            end
            OP_WR_NEW:
            begin
                wr_en = 1'b1;
                wdata = rdata_reg | REVERSE_BIT;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            sym_reg  <= symbol;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        cell_value_reg <= cell_value_next;
    end

    // sweep counter and cursor
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.op == OP_CLEAR || cmd.op == OP_FILL ||
                 (cmd.op == OP_SCROLL && !status.cnt_at_shift))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.op == OP_WR_OLD)
        begin
            case (sym_reg)
                CODE_BACKSPACE:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                CODE_LINE_FEED:
                begin
                    if (row_reg != ROW_LAST)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                CODE_CARRIAGE_RETURN:
                begin
                    col_next = '0;
                end
                default:
                begin
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        if (row_reg != ROW_LAST)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // result word
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        cell_value_next = cell_value_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            cell_value_next = (status.is_read && in_range) ? rdata_reg : 8'd0;
            out_col_next    = col_reg;
            out_row_next    = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
        end
    end

    assign col_wide   = 32'(out_col_reg);
    assign row_wide   = 32'(out_row_reg);
    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign cursor_col = col_wide[6:0];
    assign cursor_row = row_wide[4:0];

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`default_nettype none

// Glass-tty character writer over a ROWS x COLUMNS screen memory with a
// reverse-video cursor. After reset a clearing pass writes the whole screen,
// one cell per cycle, with in_stall high all along. A read word then goes
// through the fetch and done states, a put word through fetch, write-old,
// read-new, write-new and done, each bound by the single read and single
// write port of the screen memory. A put that scrolls (line feed or wrap on
// the bottom row) walks the memory once more: every row moves up by one, then
// the bottom row is filled with spaces. A new word is taken while a result
// waits on out_stall; a finished result waits only if the previous is held.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       command,
    input  wire logic [7:0] symbol,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      cell_value,
    output logic [6:0]      cursor_col,
    output logic [4:0]      cursor_row
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .command    (command),
        .symbol     (symbol),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row)
    );

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] cell_value,
    input wire logic [6:0] cursor_col,
    input wire logic [4:0] cursor_row
);

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_value) &&
            $stable(cursor_col) && $stable(cursor_row))
        else $error("held result word changed");

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("no busy cycle after accept");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    // reported cursor lies on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS))
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_value (cell_value),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
);

`default_nettype wire
